### src/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg: first-fit page allocator shared types
// Opcodes, status codes, register indexes, request/result payloads and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

  localparam int unsigned MaxPages = 1024;

  localparam logic [16:0] PageBytesReset = 17'd4096;
  localparam logic [10:0] PoolPagesReset = 11'd1024;
  localparam logic [16:0] PageBytesMin   = 17'd4;
  localparam logic [16:0] PageBytesMax   = 17'd65536;

  typedef enum logic [2:0] {
    OP_ALLOC    = 3'd0,
    OP_ALLOC_MUL = 3'd1,
    OP_RESERVE  = 3'd2,
    OP_FREE     = 3'd3,
    OP_FREE_ALL = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_RANGE    = 3'd2,
    ST_OVERLAP  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_POOL_BASE  = 2'd0,
    REG_PAGE_BYTES = 2'd1,
    REG_POOL_PAGES = 2'd2
  } reg_index_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_PROD,
    S_PCHK,
    S_DIV,
    S_QUOT,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] size;
    logic [31:0] count;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] block_address;
    logic [2:0]  status;
  } rsp_t;

endpackage

`default_nettype wire

### src/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram: generic single-port-write RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/first_fit_page_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator_core: first-fit page allocator
// Allocate, reserve and free page segments of a pool held in a page table RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_stall_o, results leave on
//   out_valid_o/out_stall_i, one result per request. Config writes use
//   cfg_valid_i/cfg_ready_o; the user must issue them only while the block
//   is idle, as the block itself does not enforce it. One request at a
//   time: in_stall_o is high from acceptance until the result is loaded
//   into the output register. Steps: a setup state, a bit-serial divider
//   plus a state to take the quotient (twice for reserve), then a walk of
//   the page table at one entry or segment per cycle up to the active page
//   count, then a response state, held while a stalled result still fills
//   the output register. Allocate of size*count adds S_PROD and S_PCHK.
//   Free all sweeps MAX_PAGES entries, one per cycle.
//   Reset clears the page table with a sweep of all MAX_PAGES entries,
//   during which no request is taken. A stalled result holds in the output
//   register while the next request may already be accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_page_allocator_core #(
  parameter int unsigned MAX_PAGES = ffpa_pkg::MaxPages
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ffpa_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ffpa_pkg::rsp_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_PAGES);
  localparam int unsigned LW = $clog2(MAX_PAGES + 1);
  localparam int unsigned IW = LW + 1;
  localparam int unsigned EW = ((LW + 17 > 32) ? LW + 17 : 32) + 1;

  // configuration
  logic [31:0] pool_base_q;
  logic [16:0] page_bytes_q;
  logic [10:0] pool_pages_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= 32'd0;
      page_bytes_q <= ffpa_pkg::PageBytesReset;
      pool_pages_q <= ffpa_pkg::PoolPagesReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ffpa_pkg::REG_POOL_BASE:  pool_base_q  <= cfg_data_i;
        ffpa_pkg::REG_PAGE_BYTES: page_bytes_q <= cfg_data_i[16:0];
        ffpa_pkg::REG_POOL_PAGES: pool_pages_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  logic [16:0]   ps;
  logic [LW-1:0] n_pages;
  logic [16:0]   pp_ext;

  always_comb begin
    if (page_bytes_q < ffpa_pkg::PageBytesMin)      ps = ffpa_pkg::PageBytesMin;
    else if (page_bytes_q > ffpa_pkg::PageBytesMax) ps = ffpa_pkg::PageBytesMax;
    else                                            ps = page_bytes_q;
    pp_ext = 17'(pool_pages_q);
    if (pp_ext > 17'(MAX_PAGES)) n_pages = LW'(MAX_PAGES);
    else                         n_pages = LW'(pp_ext);
  end

  // state
  ffpa_pkg::state_e state_q, state_d;
  logic [2:0]    op_q;
  logic [31:0]   size_q, count_q, addr_q;
  logic [EW-1:0] end_q;
  logic [32:0]   dvd_q, dvd_d;
  logic [17:0]   rem_q, rem_d;
  logic [5:0]    dcnt_q, dcnt_d;
  logic          phase_q, phase_d;
  logic [32:0]   need_q, need_d, lo_q, lo_d, p_q, p_d;
  logic [33:0]   hi_q, hi_d;
  logic [IW-1:0] i_q, i_d;
  logic [LW-1:0] run_q, run_d, start_q, start_d;
  logic [63:0]   prod_q;
  logic [AW-1:0] clr_q, clr_d;
  logic          clr_resp_q, clr_resp_d;
  logic          res_ok_q, res_ok_d, res_alloc_q, res_alloc_d;
  ffpa_pkg::status_e res_st_q, res_st_d;
  logic          out_valid_q;
  ffpa_pkg::rsp_t out_data_q;

  // RAM
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [LW-1:0]   ram_wdata;
  logic [LW-1:0]   rd_data;

  ffpa_ram #(
    .Width (LW),
    .Depth (MAX_PAGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (i_d[AW-1:0]),
    .rdata_o (rd_data)
  );

  // handshake
  logic accept, out_free;
  assign in_stall_o = (state_q != ffpa_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // range checks for reserve and free
  logic in_range;
  assign in_range = (33'(addr_q) >= 33'(pool_base_q)) && (EW'(addr_q) < end_q);

  // divider step: restoring, one quotient bit a cycle
  logic [17:0] div_r;
  logic        div_ge;
  assign div_r  = {rem_q[16:0], dvd_q[32]};
  assign div_ge = div_r >= 18'(ps);

  // page table walk step; read data belongs to entry i_q
  logic          scan_end, alloc_hit, free_hit, rsv_hit;
  logic [LW-1:0] run_new, start_new;
  logic [IW-1:0] i_step;
  logic [32:0]   i_ext, seg_end;

  always_comb begin
    scan_end  = i_q >= IW'(n_pages);
    i_ext     = 33'(i_q);
    seg_end   = i_ext + 33'(rd_data);
    run_new   = (rd_data != '0) ? '0 : run_q + LW'(1);
    start_new = (rd_data == '0 && run_q == '0) ? LW'(i_q) : start_q;
    alloc_hit = (run_new != '0) && (33'(run_new) >= need_q);
    i_step    = (rd_data != '0) ? i_q + IW'(rd_data) : i_q + IW'(1);
    free_hit  = (rd_data != '0) && (p_q >= i_ext) && (p_q < seg_end);
    rsv_hit   = (rd_data != '0) && (34'(i_q) < hi_q) && (seg_end > lo_q);
  end

  logic [33:0] hi_calc;
  assign hi_calc = 34'(dvd_q) + 34'd1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffpa_pkg::S_CLEAR: begin
        if (clr_q == AW'(MAX_PAGES - 1)) begin
          state_d = clr_resp_q ? ffpa_pkg::S_RESP : ffpa_pkg::S_IDLE;
        end
      end
      ffpa_pkg::S_IDLE: if (accept) state_d = ffpa_pkg::S_SETUP;
      ffpa_pkg::S_SETUP: begin
        priority case (op_q)
          ffpa_pkg::OP_ALLOC:     state_d = ffpa_pkg::S_DIV;
          ffpa_pkg::OP_ALLOC_MUL: state_d = ffpa_pkg::S_PROD;
          ffpa_pkg::OP_RESERVE,
          ffpa_pkg::OP_FREE:      state_d = in_range ? ffpa_pkg::S_DIV : ffpa_pkg::S_RESP;
          ffpa_pkg::OP_FREE_ALL:  state_d = ffpa_pkg::S_CLEAR;
          default:                state_d = ffpa_pkg::S_RESP;
        endcase
      end
      ffpa_pkg::S_PROD: state_d = ffpa_pkg::S_PCHK;
      ffpa_pkg::S_PCHK: state_d = (prod_q[63:32] != '0) ? ffpa_pkg::S_RESP : ffpa_pkg::S_DIV;
      ffpa_pkg::S_DIV:  if (dcnt_q == 6'd32) state_d = ffpa_pkg::S_QUOT;
      ffpa_pkg::S_QUOT: begin
        if (op_q == ffpa_pkg::OP_RESERVE && !phase_q) state_d = ffpa_pkg::S_DIV;
        else if (op_q == ffpa_pkg::OP_RESERVE && hi_calc > 34'(n_pages))
          state_d = ffpa_pkg::S_RESP;
        else state_d = ffpa_pkg::S_SCAN;
      end
      ffpa_pkg::S_SCAN: begin
        if (scan_end) state_d = ffpa_pkg::S_RESP;
        else if (op_q == ffpa_pkg::OP_RESERVE) begin
          if (rsv_hit) state_d = ffpa_pkg::S_RESP;
        end else if (op_q == ffpa_pkg::OP_FREE) begin
          if (free_hit) state_d = ffpa_pkg::S_RESP;
        end else if (alloc_hit) state_d = ffpa_pkg::S_RESP;
      end
      ffpa_pkg::S_RESP: if (out_free) state_d = ffpa_pkg::S_IDLE;
      default: state_d = ffpa_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    phase_d     = phase_q;
    need_d      = need_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    p_d         = p_q;
    i_d         = i_q;
    run_d       = run_q;
    start_d     = start_q;
    clr_d       = clr_q;
    clr_resp_d  = clr_resp_q;
    res_ok_d    = res_ok_q;
    res_alloc_d = res_alloc_q;
    res_st_d    = res_st_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    unique case (state_q)
      ffpa_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(MAX_PAGES - 1)) begin
          clr_d    = '0;
          res_ok_d = 1'b1;
          res_st_d = ffpa_pkg::ST_DONE;
        end
      end
      ffpa_pkg::S_IDLE: begin
        res_ok_d    = 1'b0;
        res_alloc_d = 1'b0;
        res_st_d    = ffpa_pkg::ST_RANGE;
        phase_d     = 1'b0;
        clr_resp_d  = 1'b0;
      end
      ffpa_pkg::S_SETUP: begin
        rem_d  = '0;
        dcnt_d = '0;
        if (op_q == ffpa_pkg::OP_ALLOC) begin
          dvd_d = 33'(size_q) + 33'(ps) + 33'd1;
        end else begin
          dvd_d = 33'(addr_q) - 33'(pool_base_q);
        end
        if (op_q == ffpa_pkg::OP_FREE_ALL) clr_resp_d = 1'b1;
      end
      ffpa_pkg::S_PROD: ;
      ffpa_pkg::S_PCHK: begin
        if (prod_q[63:32] != '0) res_st_d = ffpa_pkg::ST_NOSPACE;
        dvd_d = 33'(prod_q[31:0]) + 33'(ps) + 33'd1;
      end
      ffpa_pkg::S_DIV: begin
        rem_d  = div_ge ? div_r - 18'(ps) : div_r;
        dvd_d  = {dvd_q[31:0], div_ge};
        dcnt_d = dcnt_q + 6'd1;
      end
      ffpa_pkg::S_QUOT: begin
        i_d     = '0;
        run_d   = '0;
        start_d = '0;
        rem_d   = '0;
        dcnt_d  = '0;
        unique case (op_q)
          ffpa_pkg::OP_RESERVE: begin
            if (!phase_q) begin
              lo_d    = dvd_q;
              phase_d = 1'b1;
              dvd_d   = 33'(addr_q) + 33'(size_q) - 33'(pool_base_q);
            end else begin
              hi_d = hi_calc;
            end
          end
          ffpa_pkg::OP_FREE: p_d = dvd_q;
          default:           need_d = dvd_q;
        endcase
      end
      ffpa_pkg::S_SCAN: begin
        i_d = i_step;
        unique case (op_q)
          ffpa_pkg::OP_RESERVE: begin
            if (scan_end) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(lo_q);
              ram_wdata = LW'(hi_q - 34'(lo_q));
              res_ok_d  = 1'b1;
              res_st_d  = ffpa_pkg::ST_DONE;
            end else if (rsv_hit) begin
              res_st_d = ffpa_pkg::ST_OVERLAP;
            end
          end
          ffpa_pkg::OP_FREE: begin
            if (scan_end) begin
              res_st_d = ffpa_pkg::ST_NOTFOUND;
            end else if (free_hit) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(i_q);
              res_ok_d  = 1'b1;
              res_st_d  = ffpa_pkg::ST_DONE;
            end
          end
          default: begin
            run_d   = run_new;
            start_d = start_new;
            if (scan_end) begin
              res_st_d = ffpa_pkg::ST_NOSPACE;
            end else if (alloc_hit) begin
              ram_we      = 1'b1;
              ram_waddr   = AW'(start_new);
              ram_wdata   = LW'(need_q);
              start_d     = start_new;
              res_ok_d    = 1'b1;
              res_alloc_d = 1'b1;
              res_st_d    = ffpa_pkg::ST_DONE;
            end
          end
        endcase
      end
      ffpa_pkg::S_RESP: ;
      default: ;
    endcase
  end

  logic [31:0] head_addr;
  assign head_addr = 32'(33'(pool_base_q) + 33'(start_q) * 33'(ps) + 33'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffpa_pkg::S_CLEAR;
      clr_q       <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      phase_q     <= 1'b0;
      i_q         <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_resp_q <= clr_resp_d;
      dcnt_q     <= dcnt_d;
      phase_q    <= phase_d;
      i_q        <= i_d;
      if (state_q == ffpa_pkg::S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    end_q       <= EW'(pool_base_q) + EW'(n_pages) * EW'(ps);
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    need_q      <= need_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    p_q         <= p_d;
    run_q       <= run_d;
    start_q     <= start_d;
    res_ok_q    <= res_ok_d;
    res_alloc_q <= res_alloc_d;
    res_st_q    <= res_st_d;
    if (accept) begin
      op_q    <= in_data_i.opcode;
      size_q  <= in_data_i.size;
      count_q <= in_data_i.count;
      addr_q  <= in_data_i.address;
    end
    if (state_q == ffpa_pkg::S_PROD) begin
      prod_q <= 64'(size_q) * 64'(count_q);
    end
    if (state_q == ffpa_pkg::S_RESP && out_free) begin
      out_data_q.ok            <= res_ok_q;
      out_data_q.block_address <= res_alloc_q ? head_addr : 32'd0;
      out_data_q.status        <= res_st_q;
    end
  end

endmodule

`default_nettype wire
